// File: src/scon_pkg.sv
// Shared constants, request kinds and the grid command struct for the
// scrolling text console. Used by scon_grid and scrolling_text_console_core.
`timescale 1ns / 1ps
`default_nettype none

package scon_pkg;

   // Geometry of the text grid and the line capture buffer.
   localparam int ROWS     = 6;
   localparam int COLS     = 21;
   localparam int LINE_CAP = 96;

   localparam int ROW_W   = $clog2(ROWS);
   localparam int COL_W   = $clog2(COLS + 1);
   localparam int LINE_W  = $clog2(LINE_CAP);
   localparam int LIM_W   = LINE_W + 1;
   localparam int GRID_AW = ROW_W + COL_W;
   localparam int CHAR_W  = 7;

   // Byte codes that the console treats specially.
   localparam logic [7:0] CHR_LF   = 8'h0A;
   localparam logic [7:0] CHR_BS   = 8'h08;
   localparam logic [7:0] CHR_CR   = 8'h0D;
   localparam logic [7:0] CHR_LOW  = 8'd32;
   localparam logic [7:0] CHR_HIGH = 8'd126;
   localparam logic [CHAR_W-1:0] CHR_DOT = 7'h2E;

   // Request kinds carried in tuser.
   typedef enum logic [2:0] {
      KIND_BYTE      = 3'd0,
      KIND_READ_CELL = 3'd1,
      KIND_READ_LINE = 3'd2,
      KIND_RELEASE   = 3'd3,
      KIND_CLEAR     = 3'd4
   } kind_type;

   // Command word for the grid store. Rows are logical (screen) rows.
   typedef struct packed {
      logic              wr_en;
      logic [ROW_W-1:0]  wr_row;
      logic [COL_W-1:0]  wr_col;
      logic [CHAR_W-1:0] wr_data;
      logic              clr_cell_en;
      logic [ROW_W-1:0]  clr_row;
      logic [COL_W-1:0]  clr_col;
      logic              scroll;
      logic              clear_all;
      logic              rd_en;
      logic [ROW_W-1:0]  rd_row;
      logic [COL_W-1:0]  rd_col;
   } grid_cmd_type;

   // Map a screen row onto a physical memory row, given the row at the top.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                 input logic [ROW_W-1:0] row);
      logic [ROW_W:0] sum;
      sum = {1'b0, base} + {1'b0, row};
      if (sum >= (ROW_W + 1)'(ROWS)) begin
         sum = sum - (ROW_W + 1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/scon_grid.sv
// Text grid store: one synchronous memory, a valid flag per cell and a
// rotating top-row pointer so a scroll moves no characters. Depends on scon_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scon_grid (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire scon_pkg::grid_cmd_type     cmd,
   output logic [scon_pkg::CHAR_W-1:0]     rd_data
);
   import scon_pkg::*;

   logic [CHAR_W-1:0]          mem [ROWS * (2 ** COL_W)];
   logic [CHAR_W-1:0]          mem_rd_ff;
   logic [ROWS-1:0][COLS:0]    valid_ff;
   logic [ROWS-1:0][COLS:0]    valid_in;
   logic [ROW_W-1:0]           base_ff;
   logic [ROW_W-1:0]           base_in;
   logic                       hit_ff;
   logic                       hit_in;
   logic [ROW_W-1:0]           wr_phys;
   logic [ROW_W-1:0]           clr_phys;
   logic [ROW_W-1:0]           rd_phys;

   assign wr_phys  = phys_row(base_ff, cmd.wr_row);
   assign clr_phys = phys_row(base_ff, cmd.clr_row);
   assign rd_phys  = phys_row(base_ff, cmd.rd_row);

   // Character memory, written synchronously and read through a register.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[{wr_phys, cmd.wr_col}] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         mem_rd_ff <= mem[{rd_phys, cmd.rd_col}];
      end
   end

   // Cell flags: a cell that is not valid reads as empty.
   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      hit_in   = hit_ff;
      if (cmd.wr_en) begin
         valid_in[wr_phys][cmd.wr_col] = 1'b1;
      end
      if (cmd.clr_cell_en) begin
         valid_in[clr_phys][cmd.clr_col] = 1'b0;
      end
      // The old top row becomes the new, empty bottom row.
      if (cmd.scroll) begin
         valid_in[base_ff] = '0;
         base_in = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + 1'b1;
      end
      if (cmd.clear_all) begin
         valid_in = '0;
         base_in  = '0;
      end
      if (cmd.rd_en) begin
         hit_in = valid_ff[rd_phys][cmd.rd_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         base_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         base_ff  <= base_in;
         hit_ff   <= hit_in;
      end
   end

   assign rd_data = hit_ff ? mem_rd_ff : '0;

endmodule

`default_nettype wire

// File: src/scrolling_text_console_core.sv
// Scrolling text console with line capture: request decode, cursor and
// line state, line buffer memory and result register. Depends on scon_pkg
// and scon_grid.
`timescale 1ns / 1ps
`default_nettype none

// The console takes one request at a time: a request is
// accepted and the grid or line memory is read in that same cycle; the
// result then moves into the output register once that register is free,
// after which a new request is taken. Every request gives exactly one response, which
// reports the cursor and the line state after the request. A scroll or a
// grid clear needs no pass over the memory because the grid keeps a flag per
// cell and a rotating top row, so no clearing pass runs after reset. A
// response waits in the output register until it is taken while the next
// request is already being processed.
module scrolling_text_console_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // kind[2:0]
   input  wire logic [2:0]  req_tuser,
   // byte_in[7:0], cell_row[10:8], cell_col[15:11], line_index[22:16],
   // read_limit[29:23], zero fill[31:30]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // char_out[6:0], status[7], line_ready[8], line_length[15:9],
   // cursor_row[18:16], cursor_col[23:19]
   output logic [23:0]      rsp_tdata
);
   import scon_pkg::*;

   typedef enum logic {S_IDLE, S_HOLD} state_type;
   typedef enum logic [1:0] {SEL_NONE, SEL_GRID, SEL_LINE} sel_type;

   // Request fields.
   logic [7:0] req_byte;
   logic [2:0] req_cell_row;
   logic [4:0] req_cell_col;
   logic [6:0] req_line_index;
   logic [6:0] req_read_limit;
   kind_type   req_kind;
   logic       accept;

   assign req_byte       = req_tdata[7:0];
   assign req_cell_row   = req_tdata[10:8];
   assign req_cell_col   = req_tdata[15:11];
   assign req_line_index = req_tdata[22:16];
   assign req_read_limit = req_tdata[29:23];
   assign req_kind       = kind_type'(req_tuser);

   // Control state.
   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] count_ff, count_in;
   logic              done_ff, done_in;
   sel_type           sel_ff, sel_in;
   logic              status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Response payload.
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_ready_ff, rsp_ready_in;
   logic [6:0]        rsp_len_ff, rsp_len_in;
   logic [2:0]        rsp_row_ff, rsp_row_in;
   logic [4:0]        rsp_col_ff, rsp_col_in;

   // Line buffer and grid access.
   logic [CHAR_W-1:0] line_mem [LINE_CAP];
   logic [CHAR_W-1:0] line_rd_ff;
   logic              line_we;
   logic              line_re;
   logic [LINE_W-1:0] line_addr;
   logic [CHAR_W-1:0] line_wdata;
   grid_cmd_type      gcmd;
   logic [CHAR_W-1:0] grid_data;

   // Helpers for the line read limit.
   logic [LIM_W-1:0]  limit;
   logic [LIM_W-1:0]  avail;
   logic              line_refused;
   logic [CHAR_W-1:0] shown_char;
   logic              slot_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Saturated caller limit and the number of characters that may be read.
   assign limit = (int'(req_read_limit) > LINE_CAP) ? LIM_W'(LINE_CAP)
                                                    : LIM_W'(req_read_limit);
   assign avail = (int'(count_ff) >= int'(limit)) ? limit - 1'b1
                                                  : LIM_W'(count_ff);
   assign line_refused = !done_ff || (limit == '0);

   // Non-printable bytes are shown and captured as a dot.
   assign shown_char = (req_byte < CHR_LOW || req_byte > CHR_HIGH) ? CHR_DOT
                                                                   : req_byte[6:0];

   scon_grid u_grid (
      .clock   (clock),
      .reset   (reset),
      .cmd     (gcmd),
      .rd_data (grid_data)
   );

   // Line buffer memory with a registered read port.
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_addr] <= line_wdata;
      end
      if (line_re) begin
         line_rd_ff <= line_mem[line_addr];
      end
   end

   // Request decode and next-state logic.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      sel_in        = sel_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ready_in  = rsp_ready_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      gcmd          = '0;
      line_we       = 1'b0;
      line_re       = 1'b0;
      line_addr     = count_ff;
      line_wdata    = shown_char;

      if (accept) begin
         sel_in    = SEL_NONE;
         status_in = 1'b0;
         state_in  = S_HOLD;
         unique case (req_kind)
            KIND_BYTE: begin
               if (req_byte == CHR_CR) begin
                  // Carriage return is dropped.
               end else if (req_byte == CHR_LF) begin
                  if (count_ff != '0 && !done_ff) begin
                     done_in = 1'b1;
                  end
                  col_in = '0;
                  if (row_ff < ROW_W'(ROWS - 1)) begin
                     row_in = row_ff + 1'b1;
                  end else begin
                     gcmd.scroll = 1'b1;
                  end
               end else if (req_byte == CHR_BS) begin
                  if (col_ff != '0) begin
                     col_in           = col_ff - 1'b1;
                     gcmd.clr_cell_en = 1'b1;
                     gcmd.clr_row     = row_ff;
                     gcmd.clr_col     = col_ff - 1'b1;
                  end
               end else begin
                  // Capture while the line is open and not full.
                  if (!done_ff && count_ff < LINE_W'(LINE_CAP - 1)) begin
                     line_we  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  gcmd.wr_en   = 1'b1;
                  gcmd.wr_row  = row_ff;
                  gcmd.wr_col  = col_ff;
                  gcmd.wr_data = shown_char;
                  // Advance or wrap, then clear the cell under the new cursor.
                  if (col_ff < COL_W'(COLS - 1)) begin
                     col_in           = col_ff + 1'b1;
                     gcmd.clr_cell_en = 1'b1;
                     gcmd.clr_row     = row_ff;
                     gcmd.clr_col     = col_ff + 1'b1;
                  end else begin
                     col_in = '0;
                     if (row_ff < ROW_W'(ROWS - 1)) begin
                        row_in           = row_ff + 1'b1;
                        gcmd.clr_cell_en = 1'b1;
                        gcmd.clr_row     = row_ff + 1'b1;
                        gcmd.clr_col     = '0;
                     end else begin
                        // The new bottom row is cleared by the scroll.
                        gcmd.scroll = 1'b1;
                     end
                  end
               end
            end
            KIND_READ_CELL: begin
               if (int'(req_cell_row) < ROWS && int'(req_cell_col) <= COLS) begin
                  gcmd.rd_en  = 1'b1;
                  gcmd.rd_row = ROW_W'(req_cell_row);
                  gcmd.rd_col = COL_W'(req_cell_col);
                  sel_in      = SEL_GRID;
               end
            end
            KIND_READ_LINE: begin
               if (line_refused) begin
                  status_in = 1'b1;
               end else if (int'(req_line_index) < int'(avail) &&
                            int'(req_line_index) < LINE_CAP) begin
                  line_re   = 1'b1;
                  line_addr = LINE_W'(req_line_index);
                  sel_in    = SEL_LINE;
               end
            end
            KIND_RELEASE: begin
               if (line_refused) begin
                  status_in = 1'b1;
               end else begin
                  done_in  = 1'b0;
                  count_in = '0;
               end
            end
            KIND_CLEAR: begin
               gcmd.clear_all = 1'b1;
               row_in         = '0;
               col_in         = '0;
            end
            default: begin
               // Unused kinds change nothing.
            end
         endcase
      end

      // Move the finished result into the output register.
      if (state_ff == S_HOLD && slot_free) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         unique case (sel_ff)
            SEL_GRID: rsp_char_in = grid_data;
            SEL_LINE: rsp_char_in = line_rd_ff;
            default:  rsp_char_in = '0;
         endcase
         rsp_status_in = status_ff;
         rsp_ready_in  = done_ff;
         rsp_len_in    = 7'(count_ff);
         rsp_row_in    = 3'(row_ff);
         rsp_col_in    = 5'(col_ff);
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         sel_ff       <= SEL_NONE;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         sel_ff       <= sel_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ready_ff  <= rsp_ready_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rsp_len_ff, rsp_ready_ff,
                        rsp_status_ff, rsp_char_ff};

endmodule

`default_nettype wire
